// ===== rtl/rpd_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helper functions of the random early drop block
// no dependencies

package rpd_pkg;

   localparam int Q_W        = 10;
   localparam int PROB_BITS  = 16;
   localparam int PROB_W     = PROB_BITS + 1;
   localparam int SAMPLE_W   = 16;
   localparam int TAG_W      = 32;
   localparam int CNT_W      = 32;
   localparam int PROD_W     = PROB_W + Q_W;
   localparam int DIV_STEPS  = PROB_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = PROB_W;

   localparam logic [Q_W-1:0]    QUEUE_MAX = Q_W'(1023);
   localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(1) << PROB_BITS;

   localparam logic [Q_W-1:0]    MIN_THR_RESET = Q_W'(5);
   localparam logic [Q_W-1:0]    MAX_THR_RESET = Q_W'(15);
   localparam logic [PROB_W-1:0] P_MIN_RESET   = PROB_W'(0);
   localparam logic [PROB_W-1:0] P_MAX_RESET   = PROB_W'(6554);

   localparam logic [CSR_IDX_W-1:0] REG_MIN_THR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_THR = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_P_MIN   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_P_MAX   = CSR_IDX_W'(3);

   localparam logic ACT_PACKET = 1'b0;
   localparam logic ACT_REPORT = 1'b1;

   typedef struct packed {
      logic [Q_W-1:0]    min_thr;
      logic [Q_W-1:0]    max_thr;
      logic [PROB_W-1:0] p_min;
      logic [PROB_W-1:0] p_max;
   } cfg_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_DIV  = 5'b00100,
      S_FIN  = 5'b01000,
      S_PEND = 5'b10000
   } state_type;

   typedef struct packed {
      logic pkt_out;
      logic pkt_pend;
      logic pend_out;
      logic rpt_direct;
      logic rpt_start;
      logic mul_go;
      logic div_step;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic interp;
      logic div_last;
   } status_type;

   function automatic logic [Q_W-1:0] sat_queue(input logic [Q_W-1:0] v);
      return (v > QUEUE_MAX) ? QUEUE_MAX : v;
   endfunction

   function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] v);
      return (v > PROB_ONE) ? PROB_ONE : v;
   endfunction

endpackage

// ===== rtl/rpd_csr.sv =====
`timescale 1ns / 1ps
// configuration registers: thresholds and end-point probabilities
// depends on rpd_pkg

module rpd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rpd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output rpd_pkg::cfg_type                  cfg
);

   rpd_pkg::cfg_type cfg_ff;
   rpd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rpd_pkg::REG_MIN_THR: cfg_in.min_thr = csr_wdata[rpd_pkg::Q_W-1:0];
            rpd_pkg::REG_MAX_THR: cfg_in.max_thr = csr_wdata[rpd_pkg::Q_W-1:0];
            rpd_pkg::REG_P_MIN:   cfg_in.p_min   = csr_wdata;
            rpd_pkg::REG_P_MAX:   cfg_in.p_max   = csr_wdata;
            default:              cfg_in         = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_thr <= rpd_pkg::MIN_THR_RESET;
         cfg_ff.max_thr <= rpd_pkg::MAX_THR_RESET;
         cfg_ff.p_min   <= rpd_pkg::P_MIN_RESET;
         cfg_ff.p_max   <= rpd_pkg::P_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/rpd_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for packet decisions and queue report interpolation
// depends on rpd_pkg

module rpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_stall,
   input  rpd_pkg::status_type  status,
   output rpd_pkg::cmd_type     cmd
);

   rpd_pkg::state_type state_ff;
   rpd_pkg::state_type state_in;

   assign req_stall = (state_ff != rpd_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         rpd_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_action == rpd_pkg::ACT_PACKET) begin
                  if (status.out_free) begin
                     cmd.pkt_out = 1'b1;
                  end else begin
                     cmd.pkt_pend = 1'b1;
                     state_in     = rpd_pkg::S_PEND;
                  end
               end else if (status.interp) begin
                  cmd.rpt_start = 1'b1;
                  state_in      = rpd_pkg::S_MUL;
               end else begin
                  cmd.rpt_direct = 1'b1;
               end
            end
         end
         rpd_pkg::S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = rpd_pkg::S_DIV;
         end
         rpd_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = rpd_pkg::S_FIN;
            end
         end
         rpd_pkg::S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = rpd_pkg::S_IDLE;
         end
         rpd_pkg::S_PEND: begin
            if (status.out_free) begin
               cmd.pend_out = 1'b1;
               state_in     = rpd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rpd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/rpd_dpath.sv =====
`timescale 1ns / 1ps
// datapath: probability register, drop counter, multiply and restoring divider,
// pending and output beat registers; depends on rpd_pkg

module rpd_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  rpd_pkg::cfg_type                  cfg,
   input  rpd_pkg::cmd_type                  cmd,
   output rpd_pkg::status_type               status,
   input  logic [rpd_pkg::Q_W-1:0]           req_queue_length,
   input  logic [rpd_pkg::SAMPLE_W-1:0]      req_random_sample,
   input  logic [rpd_pkg::TAG_W-1:0]         req_packet_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_drop_notice,
   output logic [rpd_pkg::TAG_W-1:0]         rsp_tag_out,
   output logic [rpd_pkg::CNT_W-1:0]         rsp_drops_so_far
);

   localparam int PW = rpd_pkg::PROB_W;
   localparam int QW = rpd_pkg::Q_W;

   // kept state
   logic [PW-1:0]               prob_ff, prob_in;
   logic [rpd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   // output and pending beats
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_drop_ff;
   logic [rpd_pkg::TAG_W-1:0]   out_tag_ff;
   logic [rpd_pkg::CNT_W-1:0]   out_cnt_ff;
   logic                        pend_drop_ff;
   logic [rpd_pkg::TAG_W-1:0]   pend_tag_ff;
   logic [rpd_pkg::CNT_W-1:0]   pend_cnt_ff;

   // interpolation operands and divider
   logic [QW-1:0]                   qoff_ff;
   logic [QW-1:0]                   span_ff;
   logic [PW-1:0]                   plo_ff;
   logic [PW-1:0]                   mag_ff;
   logic                            neg_ff;
   logic [QW-1:0]                   rem_ff, rem_in;
   logic [PW-1:0]                   work_ff;
   logic [PW-1:0]                   quot_ff;
   logic [rpd_pkg::DIV_CNT_W-1:0]   step_ff;

   logic [QW-1:0]             lo, hi, q;
   logic [PW-1:0]             plo, phi, p_direct;
   logic                      interp;
   logic                      drop;
   logic [rpd_pkg::CNT_W-1:0] cnt_next;
   logic [rpd_pkg::TAG_W-1:0] tag_sel;
   logic [rpd_pkg::PROD_W-1:0] prod;
   logic [QW:0]               trial;
   logic                      ge;
   logic [PW:0]               p_fin;
   logic                      out_free;

   assign lo  = rpd_pkg::sat_queue(cfg.min_thr);
   assign hi  = rpd_pkg::sat_queue(cfg.max_thr);
   assign plo = rpd_pkg::sat_prob(cfg.p_min);
   assign phi = rpd_pkg::sat_prob(cfg.p_max);
   assign q   = rpd_pkg::sat_queue(req_queue_length);

   // tests apply in order, the last match wins
   always_comb begin
      p_direct = '0;
      if (q == lo) begin
         p_direct = plo;
      end
      if (q == hi) begin
         p_direct = phi;
      end
      if (q > hi) begin
         p_direct = rpd_pkg::PROB_ONE;
      end
   end

   assign interp = (q > lo) && (q < hi);

   // packet decision
   assign drop     = {1'b0, req_random_sample} < prob_ff;
   assign cnt_next = drop ? (cnt_ff + rpd_pkg::CNT_W'(1)) : cnt_ff;
   assign tag_sel  = drop ? '0 : req_packet_tag;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign prod  = rpd_pkg::PROD_W'(mag_ff) * rpd_pkg::PROD_W'(qoff_ff);
   assign trial = {rem_ff, work_ff[PW-1]};
   assign ge    = trial >= {1'b0, span_ff};
   assign rem_in = ge ? QW'(trial - {1'b0, span_ff}) : trial[QW-1:0];
   assign p_fin = neg_ff ? ({1'b0, plo_ff} - {1'b0, quot_ff})
                         : ({1'b0, plo_ff} + {1'b0, quot_ff});

   always_comb begin
      prob_in = prob_ff;
      if (cmd.rpt_direct) begin
         prob_in = p_direct;
      end else if (cmd.fin) begin
         prob_in = p_fin[PW-1:0];
      end
   end

   assign cnt_in = (cmd.pkt_out || cmd.pkt_pend) ? cnt_next : cnt_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.pkt_out || cmd.pend_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prob_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prob_ff      <= prob_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pkt_out) begin
         out_drop_ff <= drop;
         out_tag_ff  <= tag_sel;
         out_cnt_ff  <= cnt_next;
      end else if (cmd.pend_out) begin
         out_drop_ff <= pend_drop_ff;
         out_tag_ff  <= pend_tag_ff;
         out_cnt_ff  <= pend_cnt_ff;
      end
      if (cmd.pkt_pend) begin
         pend_drop_ff <= drop;
         pend_tag_ff  <= tag_sel;
         pend_cnt_ff  <= cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rpt_start) begin
         qoff_ff <= q - lo;
         span_ff <= hi - lo;
         plo_ff  <= plo;
         neg_ff  <= phi < plo;
         mag_ff  <= (phi < plo) ? (plo - phi) : (phi - plo);
      end
      if (cmd.mul_go) begin
         // quotient stays below 2^PROB_W, so the top bits already sit below the span
         rem_ff  <= prod[rpd_pkg::PROD_W-1:PW];
         work_ff <= prod[PW-1:0];
         quot_ff <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         work_ff <= {work_ff[PW-2:0], 1'b0};
         quot_ff <= {quot_ff[PW-2:0], ge};
         step_ff <= step_ff + rpd_pkg::DIV_CNT_W'(1);
      end
   end

   assign status.out_free = out_free;
   assign status.interp   = interp;
   assign status.div_last = (step_ff == rpd_pkg::DIV_CNT_W'(rpd_pkg::DIV_STEPS - 1));

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drop_notice  = out_drop_ff;
   assign rsp_tag_out      = out_tag_ff;
   assign rsp_drops_so_far = out_cnt_ff;

endmodule

// ===== rtl/red_packet_dropper.sv =====
`timescale 1ns / 1ps
// Random early detection admission block. A queue report (action 1) sets the kept drop
// probability and gives no result beat; a packet (action 0) drops when its random sample is
// below that probability and gives one beat: the tag when admitted, or a drop notice with
// the wrapping drop count. After a packet the block accepts the next item in the
// following cycle; if the result register is still stalled the packet is parked in a
// pending register and input stalls until the result register frees. A report whose length
// lies at or outside the thresholds is set directly; one strictly between them stalls input
// through a multiply step, a 17-step restoring divider by the threshold span that retires
// one quotient bit a cycle, and a final add. Configuration writes are always ready.
// depends on rpd_pkg, rpd_csr, rpd_ctrl, rpd_dpath

module red_packet_dropper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [rpd_pkg::Q_W-1:0]           req_queue_length,
   input  logic [rpd_pkg::SAMPLE_W-1:0]      req_random_sample,
   input  logic [rpd_pkg::TAG_W-1:0]         req_packet_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_drop_notice,
   output logic [rpd_pkg::TAG_W-1:0]         rsp_tag_out,
   output logic [rpd_pkg::CNT_W-1:0]         rsp_drops_so_far,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rpd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rpd_pkg::cfg_type    cfg;
   rpd_pkg::cmd_type    cmd;
   rpd_pkg::status_type status;

   rpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   rpd_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_queue_length  (req_queue_length),
      .req_random_sample (req_random_sample),
      .req_packet_tag    (req_packet_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drop_notice   (rsp_drop_notice),
      .rsp_tag_out       (rsp_tag_out),
      .rsp_drops_so_far  (rsp_drops_so_far)
   );

endmodule

// ===== rtl/rpd_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the random early drop block, bound to the top level
// depends on rpd_pkg and red_packet_dropper

module rpd_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_action,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_drop_notice,
   input  logic [rpd_pkg::TAG_W-1:0]         rsp_tag_out,
   input  logic [rpd_pkg::CNT_W-1:0]         rsp_drops_so_far
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drop_notice)
         && $stable(rsp_tag_out) && $stable(rsp_drops_so_far))
      else $error("stalled result beat changed");

   // a drop notice never carries a tag
   a_drop_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drop_notice |-> rsp_tag_out == '0)
      else $error("drop notice with nonzero tag");

   // a packet taken while the result is stalled parks and blocks input
   a_park: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == rpd_pkg::ACT_PACKET)
         && rsp_valid && rsp_stall |=> req_stall)
      else $error("input not stalled while a packet is parked");

   // no result beat right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind red_packet_dropper rpd_checker u_rpd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_action       (req_action),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_drop_notice  (rsp_drop_notice),
   .rsp_tag_out      (rsp_tag_out),
   .rsp_drops_so_far (rsp_drops_so_far)
);
